[rtl/core/tbur_pkg.sv]
`timescale 1ns / 1ps

package tbur_pkg;

    localparam int DOC_DEPTH  = 256;
    localparam int HIST_DEPTH = 64;

    localparam int DOC_AW  = $clog2(DOC_DEPTH);
    localparam int LEN_W   = $clog2(DOC_DEPTH + 1);
    localparam int CMP_W   = (LEN_W > 9) ? LEN_W : 9;
    localparam int HIST_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HCNT_W  = $clog2(HIST_DEPTH + 1);

    typedef logic [DOC_AW-1:0]  t_addr;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [CMP_W-1:0]   t_cmp;
    typedef logic [HIST_AW-1:0] t_hptr;
    typedef logic [HCNT_W-1:0]  t_hcnt;
    typedef logic [HCNT_W:0]    t_hsum;

    typedef enum logic [2:0] {
        K_INS  = 3'd0,
        K_DEL  = 3'd1,
        K_UNDO = 3'd2,
        K_REDO = 3'd3,
        K_READ = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_INS,
        OP_REM,
        OP_RD
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HWAIT,
        S_CHECK,
        S_SHIFT,
        S_TAIL,
        S_PUT,
        S_FINISH,
        S_DONE
    } t_state;

    // history entry: edit type, position, character
    typedef struct packed {
        logic       is_del;
        logic [7:0] pos;
        logic [7:0] chr;
    } t_hent;

    // circular slot from a sum that stays below twice the depth
    function automatic t_hptr hwrap(input t_hsum s);
        t_hsum d;
        d = t_hsum'(HIST_DEPTH);
        if (s >= d) begin
            hwrap = t_hptr'(s - d);
        end else begin
            hwrap = t_hptr'(s);
        end
    endfunction

endpackage

[rtl/core/text_buffer_undo_redo_top.sv]
`timescale 1ns / 1ps

// steps: decode, a history read for undo/redo, a range check, a move of the
// characters behind the position for insert and delete (none for an append),
// then the update and the result; throughput: one word at a time; the document
// memory moves one character per cycle through one read and one write port
// reset: synchronous active-low i_rst_n empties the document and the history at once
module text_buffer_undo_redo_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] position, [15:8] char_in
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [8:0] doc_length, [16:9] char_out, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    tbur_pkg::t_state  r_state, n_state;
    logic [2:0]        r_kind, n_kind;
    logic [7:0]        r_pos, n_pos;
    logic [7:0]        r_ch, n_ch;
    tbur_pkg::t_op     r_op, n_op;
    logic [7:0]        r_opos, n_opos;
    logic [7:0]        r_och, n_och;
    tbur_pkg::t_len    r_len, n_len;
    tbur_pkg::t_hptr   r_oldest, n_oldest;
    tbur_pkg::t_hcnt   r_undo, n_undo;
    tbur_pkg::t_hcnt   r_redo, n_redo;
    tbur_pkg::t_addr   r_rd, n_rd;
    tbur_pkg::t_addr   r_prev, n_prev;
    logic              r_pend, n_pend;
    tbur_pkg::t_status r_status, n_status;
    logic [7:0]        r_got, n_got;
    logic              r_m_valid, n_m_valid;
    logic [23:0]       r_m_data, n_m_data;
    logic [1:0]        r_m_user, n_m_user;

    logic [7:0]        doc_mem [tbur_pkg::DOC_DEPTH];
    logic [7:0]        r_doc_q;
    logic              doc_we, doc_re;
    tbur_pkg::t_addr   doc_waddr, doc_raddr;
    logic [7:0]        doc_wdata;

    logic [16:0]       hist_mem [tbur_pkg::HIST_DEPTH];
    logic [16:0]       r_hist_q;
    logic              hist_we, hist_re;
    tbur_pkg::t_hptr   hist_waddr, hist_raddr;
    tbur_pkg::t_hent   hist_wdata;
    tbur_pkg::t_hent   hent;

    tbur_pkg::t_cmp    pos_ext, len_ext;
    tbur_pkg::t_addr   opos_addr, len_m1;
    tbur_pkg::t_hptr   slot_top, slot_undo;
    logic              last_rd, hist_full;

    assign s_axis_tready = (r_state == tbur_pkg::S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    assign hent      = tbur_pkg::t_hent'(r_hist_q);
    assign pos_ext   = tbur_pkg::t_cmp'(r_opos);
    assign len_ext   = tbur_pkg::t_cmp'(r_len);
    assign opos_addr = tbur_pkg::t_addr'(r_opos);
    assign len_m1    = tbur_pkg::t_addr'(r_len - tbur_pkg::t_len'(1));
    assign hist_full = (r_undo == tbur_pkg::t_hcnt'(tbur_pkg::HIST_DEPTH));
    assign slot_top  = tbur_pkg::hwrap(tbur_pkg::t_hsum'(r_oldest) + tbur_pkg::t_hsum'(r_undo));
    assign slot_undo = tbur_pkg::hwrap(tbur_pkg::t_hsum'(r_oldest) + tbur_pkg::t_hsum'(r_undo)
                                       - tbur_pkg::t_hsum'(1));
    assign last_rd   = (r_op == tbur_pkg::OP_REM) ? (r_rd == len_m1) : (r_rd == opos_addr);

    always_ff @(posedge i_clk) begin
        if (doc_we) begin
            doc_mem[doc_waddr] <= doc_wdata;
        end
        if (doc_re) begin
            r_doc_q <= doc_mem[doc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_re) begin
            r_hist_q <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tbur_pkg::S_IDLE;
            r_len     <= '0;
            r_oldest  <= '0;
            r_undo    <= '0;
            r_redo    <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_oldest  <= n_oldest;
            r_undo    <= n_undo;
            r_redo    <= n_redo;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_pos    <= n_pos;
        r_ch     <= n_ch;
        r_op     <= n_op;
        r_opos   <= n_opos;
        r_och    <= n_och;
        r_rd     <= n_rd;
        r_prev   <= n_prev;
        r_status <= n_status;
        r_got    <= n_got;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_pos      = r_pos;
        n_ch       = r_ch;
        n_op       = r_op;
        n_opos     = r_opos;
        n_och      = r_och;
        n_len      = r_len;
        n_oldest   = r_oldest;
        n_undo     = r_undo;
        n_redo     = r_redo;
        n_rd       = r_rd;
        n_prev     = r_prev;
        n_pend     = r_pend;
        n_status   = r_status;
        n_got      = r_got;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;
        n_m_user   = r_m_user;
        doc_we     = 1'b0;
        doc_waddr  = r_prev;
        doc_wdata  = r_doc_q;
        doc_re     = 1'b0;
        doc_raddr  = r_rd;
        hist_we    = 1'b0;
        hist_waddr = slot_top;
        hist_wdata = '0;
        hist_re    = 1'b0;
        hist_raddr = slot_top;

        // retire the word read in the previous cycle of the move
        if ((r_state == tbur_pkg::S_SHIFT || r_state == tbur_pkg::S_TAIL) && r_pend) begin
            case (r_op)
                tbur_pkg::OP_INS: begin
                    doc_we    = 1'b1;
                    doc_waddr = r_prev + tbur_pkg::t_addr'(1);
                end
                tbur_pkg::OP_REM: begin
                    if (r_prev == opos_addr) begin
                        n_got = r_doc_q;
                    end else begin
                        doc_we    = 1'b1;
                        doc_waddr = r_prev - tbur_pkg::t_addr'(1);
                    end
                end
                default: begin
                    n_got = r_doc_q;
                end
            endcase
        end

        case (r_state)
            tbur_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind   = s_axis_tuser;
                    n_pos    = s_axis_tdata[7:0];
                    n_ch     = s_axis_tdata[15:8];
                    n_got    = 8'd0;
                    n_status = tbur_pkg::ST_DONE;
                    n_state  = tbur_pkg::S_DECODE;
                end
            end
            tbur_pkg::S_DECODE: begin
                n_opos  = r_pos;
                n_och   = r_ch;
                n_state = tbur_pkg::S_CHECK;
                case (r_kind)
                    tbur_pkg::K_INS:  n_op = tbur_pkg::OP_INS;
                    tbur_pkg::K_DEL:  n_op = tbur_pkg::OP_REM;
                    tbur_pkg::K_READ: n_op = tbur_pkg::OP_RD;
                    tbur_pkg::K_UNDO: begin
                        if (r_undo == '0) begin
                            n_status = tbur_pkg::ST_EMPTY;
                            n_state  = tbur_pkg::S_DONE;
                        end else begin
                            hist_re    = 1'b1;
                            hist_raddr = slot_undo;
                            n_state    = tbur_pkg::S_HWAIT;
                        end
                    end
                    tbur_pkg::K_REDO: begin
                        if (r_redo == '0) begin
                            n_status = tbur_pkg::ST_EMPTY;
                            n_state  = tbur_pkg::S_DONE;
                        end else begin
                            hist_re = 1'b1;
                            n_state = tbur_pkg::S_HWAIT;
                        end
                    end
                    default: n_state = tbur_pkg::S_DONE;
                endcase
            end
            tbur_pkg::S_HWAIT: begin
                // undo of an insert or redo of a delete removes
                n_op    = ((r_kind == tbur_pkg::K_UNDO) != hent.is_del) ?
                          tbur_pkg::OP_REM : tbur_pkg::OP_INS;
                n_opos  = hent.pos;
                n_och   = hent.chr;
                n_state = tbur_pkg::S_CHECK;
            end
            tbur_pkg::S_CHECK: begin
                n_pend = 1'b0;
                if (r_op == tbur_pkg::OP_INS) begin
                    if (pos_ext > len_ext) begin
                        n_status = tbur_pkg::ST_RANGE;
                        n_state  = tbur_pkg::S_DONE;
                    end else if (r_len == tbur_pkg::t_len'(tbur_pkg::DOC_DEPTH)) begin
                        n_status = tbur_pkg::ST_FULL;
                        n_state  = tbur_pkg::S_DONE;
                    end else if (pos_ext == len_ext) begin
                        n_state = tbur_pkg::S_PUT;
                    end else begin
                        n_rd    = len_m1;
                        n_state = tbur_pkg::S_SHIFT;
                    end
                end else begin
                    if (pos_ext >= len_ext) begin
                        n_status = tbur_pkg::ST_RANGE;
                        n_state  = tbur_pkg::S_DONE;
                    end else begin
                        n_rd    = opos_addr;
                        n_state = tbur_pkg::S_SHIFT;
                    end
                end
            end
            tbur_pkg::S_SHIFT: begin
                doc_re = 1'b1;
                n_prev = r_rd;
                n_pend = 1'b1;
                if (last_rd) begin
                    n_state = tbur_pkg::S_TAIL;
                end else if (r_op == tbur_pkg::OP_INS) begin
                    n_rd = r_rd - tbur_pkg::t_addr'(1);
                end else begin
                    n_rd = r_rd + tbur_pkg::t_addr'(1);
                end
            end
            tbur_pkg::S_TAIL: begin
                n_pend  = 1'b0;
                n_state = (r_op == tbur_pkg::OP_INS) ? tbur_pkg::S_PUT : tbur_pkg::S_FINISH;
            end
            tbur_pkg::S_PUT: begin
                doc_we    = 1'b1;
                doc_waddr = opos_addr;
                doc_wdata = r_och;
                if (r_kind != tbur_pkg::K_INS) begin
                    n_got = r_och;
                end
                n_state = tbur_pkg::S_FINISH;
            end
            tbur_pkg::S_FINISH: begin
                n_state = tbur_pkg::S_DONE;
                case (r_op)
                    tbur_pkg::OP_INS: n_len = r_len + tbur_pkg::t_len'(1);
                    tbur_pkg::OP_REM: n_len = r_len - tbur_pkg::t_len'(1);
                    default:          n_len = r_len;
                endcase
                case (r_kind)
                    tbur_pkg::K_INS, tbur_pkg::K_DEL: begin
                        // slot of the oldest entry when full, so it gets overwritten
                        hist_we           = 1'b1;
                        hist_wdata.is_del = (r_kind == tbur_pkg::K_DEL);
                        hist_wdata.pos    = r_pos;
                        hist_wdata.chr    = (r_kind == tbur_pkg::K_DEL) ? r_got : r_ch;
                        n_redo            = '0;
                        if (hist_full) begin
                            n_oldest = tbur_pkg::hwrap(tbur_pkg::t_hsum'(r_oldest)
                                                       + tbur_pkg::t_hsum'(1));
                        end else begin
                            n_undo = r_undo + tbur_pkg::t_hcnt'(1);
                        end
                    end
                    tbur_pkg::K_UNDO: begin
                        n_undo = r_undo - tbur_pkg::t_hcnt'(1);
                        n_redo = r_redo + tbur_pkg::t_hcnt'(1);
                    end
                    tbur_pkg::K_REDO: begin
                        n_redo = r_redo - tbur_pkg::t_hcnt'(1);
                        n_undo = r_undo + tbur_pkg::t_hcnt'(1);
                    end
                    default: ;
                endcase
            end
            tbur_pkg::S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {7'd0, r_got, 9'(r_len)};
                    n_m_user  = r_status;
                    n_state   = tbur_pkg::S_IDLE;
                end
            end
            default: n_state = tbur_pkg::S_IDLE;
        endcase
    end

endmodule

[rtl/core/tbur_chk.sv]
`timescale 1ns / 1ps

module tbur_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a result word waits for the sink
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // one word at a time: no new word taken the cycle after one was taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    // failed items never report a character
    a_err_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != 2'd0) |-> (m_axis_tdata[16:9] == 8'd0))
        else $error("error result carries a character");

    // document length never exceeds its capacity
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:0] <= 9'(tbur_pkg::DOC_DEPTH)
                           && m_axis_tdata[23:17] == 7'd0))
        else $error("document length out of range");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind text_buffer_undo_redo_top tbur_chk u_tbur_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/text_buffer_undo_redo_top_test.sv]
`timescale 1ns / 1ps

module text_buffer_undo_redo_top_test;

    // kinds the block must treat as no-ops
    localparam logic [2:0] K_NOP5 = 3'd5;
    localparam logic [2:0] K_NOP6 = 3'd6;
    localparam logic [2:0] K_NOP7 = 3'd7;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] pos;
        logic [7:0] chr;
    } t_cmd;

    typedef struct {
        tbur_pkg::t_status status;
        tbur_pkg::t_len    doc_length;
        logic [7:0]        char_out;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] position, [15:8] char_in
    logic [2:0]  s_axis_tuser = '0;   // [2:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [8:0] doc_length, [16:9] char_out, rest zero
    logic [1:0]  m_axis_tuser;        // [1:0] status

    text_buffer_undo_redo_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow of the document and the edit history
    logic [7:0]      doc_mem [tbur_pkg::DOC_DEPTH];
    int              doc_len = 0;
    tbur_pkg::t_hent hist_mem [tbur_pkg::HIST_DEPTH];
    int              hist_head = 0;
    int              undo_n = 0;
    int              redo_n = 0;

    t_cmd    cmd_q[$];
    t_answer answer_q[$];
    int      n_accepted = 0;
    int      n_fail = 0;
    logic    hold_rx = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      rx_mode = 0;
    int      rx_left = 0;
    t_answer want;

    function automatic tbur_pkg::t_status doc_insert(input int at, input logic [7:0] ch);
        int i;
        if (at > doc_len) return tbur_pkg::ST_RANGE;
        if (doc_len >= tbur_pkg::DOC_DEPTH) return tbur_pkg::ST_FULL;
        for (i = doc_len; i > at; i--) begin
            doc_mem[i] = doc_mem[i-1];
        end
        doc_mem[at] = ch;
        doc_len++;
        return tbur_pkg::ST_DONE;
    endfunction

    function automatic tbur_pkg::t_status doc_remove(input int at, output logic [7:0] ch);
        int i;
        ch = 8'h00;
        if (at >= doc_len) return tbur_pkg::ST_RANGE;
        ch = doc_mem[at];
        for (i = at; i + 1 < doc_len; i++) begin
            doc_mem[i] = doc_mem[i+1];
        end
        doc_len--;
        return tbur_pkg::ST_DONE;
    endfunction

    // new edit wipes the redo side; a full history loses its oldest entry
    function automatic void log_edit(input logic is_del, input logic [7:0] p,
                                     input logic [7:0] ch);
        redo_n = 0;
        if (undo_n >= tbur_pkg::HIST_DEPTH) begin
            hist_head = (hist_head + 1) % tbur_pkg::HIST_DEPTH;
            undo_n = tbur_pkg::HIST_DEPTH - 1;
        end
        hist_mem[(hist_head + undo_n) % tbur_pkg::HIST_DEPTH] =
            '{is_del: is_del, pos: p, chr: ch};
        undo_n++;
    endfunction

    function automatic t_answer predict_edit(input t_cmd c);
        t_answer         a;
        logic [7:0]      ch;
        tbur_pkg::t_hent e;
        int              slot;
        a.status = tbur_pkg::ST_DONE;
        a.char_out = 8'h00;
        case (c.kind)
            tbur_pkg::K_INS: begin
                a.status = doc_insert(c.pos, c.chr);
                if (a.status == tbur_pkg::ST_DONE) log_edit(1'b0, c.pos, c.chr);
            end
            tbur_pkg::K_DEL: begin
                a.status = doc_remove(c.pos, ch);
                if (a.status == tbur_pkg::ST_DONE) begin
                    a.char_out = ch;
                    log_edit(1'b1, c.pos, ch);
                end
            end
            tbur_pkg::K_UNDO, tbur_pkg::K_REDO: begin
                if ((c.kind == tbur_pkg::K_UNDO && undo_n == 0) ||
                    (c.kind == tbur_pkg::K_REDO && redo_n == 0)) begin
                    a.status = tbur_pkg::ST_EMPTY;
                end else begin
                    slot = (hist_head + undo_n - ((c.kind == tbur_pkg::K_UNDO) ? 1 : 0))
                           % tbur_pkg::HIST_DEPTH;
                    e = hist_mem[slot];
                    // undoing an insert or redoing a delete takes a character out
                    if ((c.kind == tbur_pkg::K_UNDO) != e.is_del) begin
                        a.status = doc_remove(e.pos, ch);
                        if (a.status == tbur_pkg::ST_DONE) a.char_out = ch;
                    end else begin
                        a.status = doc_insert(e.pos, e.chr);
                        if (a.status == tbur_pkg::ST_DONE) a.char_out = e.chr;
                    end
                    if (a.status == tbur_pkg::ST_DONE) begin
                        if (c.kind == tbur_pkg::K_UNDO) begin
                            undo_n--;
                            redo_n++;
                        end else begin
                            redo_n--;
                            undo_n++;
                        end
                    end
                end
            end
            tbur_pkg::K_READ: begin
                if (c.pos >= doc_len) a.status = tbur_pkg::ST_RANGE;
                else a.char_out = doc_mem[c.pos];
            end
            default: ;
        endcase
        a.doc_length = tbur_pkg::t_len'(doc_len);
        return a;
    endfunction

    function automatic void offer(input logic [2:0] k, input logic [7:0] p,
                                  input logic [7:0] ch);
        cmd_q.push_back('{kind: k, pos: p, chr: ch});
    endfunction

    // after this the shadow state reflects every word sent so far
    task automatic wait_sent();
        while (cmd_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        wait_sent();
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_mix(input int count);
        int         r;
        int         len;
        int         ins_w;
        int         run_left;
        logic [2:0] run_kind;
        run_left = 0;
        run_kind = tbur_pkg::K_UNDO;
        repeat (count) begin
            wait_sent();
            len = doc_len;
            r = $urandom_range(0, 99);
            ins_w = (len < 8) ? 55 : ((len > 40) ? 20 : 38);
            if (run_left == 0 && r < 3) begin
                run_kind = tbur_pkg::K_UNDO;
                run_left = $urandom_range(2, 30);
            end
            if (run_left > 0) begin
                offer(run_kind, 8'($urandom), 8'($urandom));
                run_left--;
                if (run_left == 0 && run_kind == tbur_pkg::K_UNDO) begin
                    run_kind = tbur_pkg::K_REDO;
                    run_left = $urandom_range(1, 30);
                end
            end else if (r < ins_w) begin
                offer(tbur_pkg::K_INS, 8'($urandom_range(0, len)), 8'($urandom));
            end else if (r < ins_w + 25) begin
                offer(tbur_pkg::K_DEL,
                      (len == 0) ? 8'($urandom) : 8'($urandom_range(0, len - 1)),
                      8'($urandom));
            end else if (r < ins_w + 38) begin
                offer(tbur_pkg::K_UNDO, 8'($urandom), 8'($urandom));
            end else if (r < ins_w + 48) begin
                offer(tbur_pkg::K_REDO, 8'($urandom), 8'($urandom));
            end else if (r < ins_w + 57) begin
                offer(tbur_pkg::K_READ,
                      (len == 0) ? 8'($urandom) : 8'($urandom_range(0, len - 1)),
                      8'($urandom));
            end else begin
                offer(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sender: bursts of words separated by idle gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                answer_q.push_back(predict_edit(cmd_q.pop_front()));
                n_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cmd_q[0].chr, cmd_q[0].pos};
                    s_axis_tuser <= cmd_q[0].kind;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: switches between random stall patterns
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_left = 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 400);
            end else begin
                rx_left--;
            end
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    // long back-pressure so the block fills and stalls its input
    initial begin
        wait (n_accepted >= 150);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (2500) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result word: status %0d len %0d char %02h",
                             m_axis_tuser, m_axis_tdata[8:0], m_axis_tdata[16:9]);
            end else begin
                want = answer_q.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata[8:0] !== want.doc_length ||
                    m_axis_tdata[16:9] !== want.char_out || m_axis_tdata[23:17] !== '0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display({"mismatch: want status %0d len %0d char %02h, ",
                                  "got %0d %0d %02h pad %h"},
                                 want.status, want.doc_length, want.char_out, m_axis_tuser,
                                 m_axis_tdata[8:0], m_axis_tdata[16:9], m_axis_tdata[23:17]);
                end
            end
        end
    end

    initial begin
        // empty document, empty stacks, edges of position
        offer(tbur_pkg::K_READ, 8'd0, 8'd0);
        offer(tbur_pkg::K_DEL, 8'd0, 8'd0);
        offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_REDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_INS, 8'd1, 8'h41);
        offer(tbur_pkg::K_INS, 8'd255, 8'h41);
        offer(tbur_pkg::K_INS, 8'd0, 8'hFF);
        offer(tbur_pkg::K_INS, 8'd1, 8'h00);
        offer(tbur_pkg::K_INS, 8'd0, 8'h5A);
        offer(tbur_pkg::K_READ, 8'd2, 8'd0);
        offer(tbur_pkg::K_READ, 8'd0, 8'd0);
        offer(tbur_pkg::K_READ, 8'd3, 8'd0);
        offer(tbur_pkg::K_READ, 8'd255, 8'hFF);
        offer(tbur_pkg::K_DEL, 8'd1, 8'd0);
        offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_REDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
        // a fresh edit drops what could be redone
        offer(tbur_pkg::K_INS, 8'd0, 8'h80);
        offer(tbur_pkg::K_REDO, 8'd0, 8'd0);
        offer(K_NOP5, 8'd255, 8'hFF);
        offer(K_NOP6, 8'd0, 8'h00);
        offer(K_NOP7, 8'd170, 8'h55);
        offer(tbur_pkg::K_DEL, 8'd255, 8'd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        random_mix(600);

        // quiet sender, then grow the document to capacity
        drain();
        while (doc_len < tbur_pkg::DOC_DEPTH) begin
            wait_sent();
            if (doc_len < 32 && $urandom_range(0, 3) == 0) begin
                offer(tbur_pkg::K_INS, 8'($urandom_range(0, doc_len)), 8'($urandom));
            end else if (doc_len > 0 && $urandom_range(0, 15) == 0) begin
                offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
                wait_sent();
                offer(tbur_pkg::K_REDO, 8'd0, 8'd0);
            end else if (doc_len > 0 && $urandom_range(0, 19) == 0) begin
                offer(tbur_pkg::K_READ, 8'($urandom_range(0, doc_len - 1)), 8'd0);
            end else begin
                offer(tbur_pkg::K_INS, 8'(doc_len), 8'($urandom));
            end
        end
        repeat (12) offer(tbur_pkg::K_INS, 8'($urandom), 8'($urandom));
        repeat (16) offer(tbur_pkg::K_READ, 8'($urandom), 8'($urandom));
        offer(tbur_pkg::K_READ, 8'd255, 8'd0);
        offer(tbur_pkg::K_DEL, 8'($urandom), 8'd0);
        offer(tbur_pkg::K_DEL, 8'd0, 8'd0);
        offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_REDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_REDO, 8'd0, 8'd0);
        offer(tbur_pkg::K_INS, 8'd255, 8'h00);
        // walk the whole history back and forward past both ends
        repeat (70) offer(tbur_pkg::K_UNDO, 8'($urandom), 8'($urandom));
        repeat (70) offer(tbur_pkg::K_REDO, 8'($urandom), 8'($urandom));
        wait_sent();
        while (doc_len > 4) begin
            wait_sent();
            if ($urandom_range(0, 19) == 0) begin
                offer(tbur_pkg::K_UNDO, 8'd0, 8'd0);
                wait_sent();
                offer(tbur_pkg::K_REDO, 8'd0, 8'd0);
            end else begin
                offer(tbur_pkg::K_DEL, 8'(doc_len - 1), 8'($urandom));
            end
        end

        random_mix(400);

        drain();
        repeat (300) @(posedge i_clk);
        if (n_fail == 0 && answer_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
